[design/flpe_pkg.sv]
// package with item types, codes and defaults for the free list pool with expiry
`timescale 1ns / 1ps

package flpe_pkg;

    // default sizes
    localparam int POOL_ENTRIES_DEF = 64;
    localparam int LIFE_BITS_DEF    = 16;

    // fixed field widths of the item ports
    localparam int LIFETIME_W = 16;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 6;
    localparam int COUNT_W    = 7;

    typedef enum logic {
        OP_CREATE = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_ZERO = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode               opcode;
        logic [LIFETIME_W-1:0] lifetime;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [COUNT_W-1:0] freed_count;
        logic [COUNT_W-1:0] free_count;
    } t_out_item;

endpackage

[design/flpe_ram.sv]
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module flpe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[design/free_list_pool_with_expiry.sv]
// top level of the free list pool with expiry
`timescale 1ns / 1ps

// Pool of POOL_ENTRIES slots on an index-linked free list, with a lifetime
// per slot. A create item pops the head slot and loads its lifetime; it passes
// through S_CREATE before its result, or reports straight from S_IDLE when it
// is rejected (pool full, or zero lifetime). A tick item walks every slot once
// through the lifetime memory's single read port, one slot a cycle, reading
// one slot ahead of the slot it updates; slots that expire are pushed onto the
// head of the free list. After reset a clearing pass loads both memories, with
// busy high. busy is high while an item is at work; each result shows on
// o_result for exactly one cycle with o_strobe high, and the receiver cannot
// stall it.
module free_list_pool_with_expiry
    import flpe_pkg::*;
#(
    parameter int POOL_ENTRIES = POOL_ENTRIES_DEF,
    parameter int LIFE_BITS    = LIFE_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int LW = $clog2(POOL_ENTRIES + 1);
    localparam int EW = (LIFE_BITS > LIFETIME_W) ? LIFE_BITS : LIFETIME_W;
    localparam logic [LW-1:0] N_L    = LW'(POOL_ENTRIES);
    localparam logic [LW-1:0] NLAST  = LW'(POOL_ENTRIES - 1);
    localparam logic [EW:0]   LMAX   = (EW + 1)'((64'd1 << LIFE_BITS) - 64'd1);

    typedef enum logic [3:0] {
        S_INIT   = 4'b0001,
        S_IDLE   = 4'b0010,
        S_CREATE = 4'b0100,
        S_TICK   = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [LW-1:0]        r_scan, n_scan;
    logic                 r_pend, n_pend;
    logic [IW-1:0]        r_pidx, n_pidx;
    logic [LW-1:0]        r_head, n_head;
    logic [LW-1:0]        r_total, n_total;
    logic [LW-1:0]        r_freed, n_freed;
    logic [LIFE_BITS-1:0] r_life, n_life;
    logic                 r_strobe, n_strobe;
    t_out_item            r_res, n_res;

    logic                 life_we;
    logic [IW-1:0]        life_waddr;
    logic [LIFE_BITS-1:0] life_wdata;
    logic [LIFE_BITS-1:0] life_rdata;
    logic                 link_we;
    logic [IW-1:0]        link_waddr;
    logic [LW-1:0]        link_wdata;
    logic [LW-1:0]        link_rdata;

    logic                 accept;
    logic                 full;
    logic                 issue;
    logic [EW:0]          life_ext;
    logic [EW:0]          life_sat;

    // fit a count into the result field
    function automatic logic [COUNT_W-1:0] to_count(input logic [LW-1:0] v);
        logic [LW+COUNT_W-1:0] w;
        w = {{COUNT_W{1'b0}}, v};
        return w[COUNT_W-1:0];
    endfunction

    // fit a slot index into the result field
    function automatic logic [SLOT_W-1:0] to_slot(input logic [LW-1:0] v);
        logic [LW+SLOT_W-1:0] w;
        w = {{SLOT_W{1'b0}}, v};
        return w[SLOT_W-1:0];
    endfunction

    // lifetime memory
    flpe_ram #(
        .WIDTH (LIFE_BITS),
        .DEPTH (POOL_ENTRIES)
    ) u_life_ram (
        .i_clk   (i_clk),
        .i_we    (life_we),
        .i_waddr (life_waddr),
        .i_wdata (life_wdata),
        .i_raddr (r_scan[IW-1:0]),
        .o_rdata (life_rdata)
    );

    // free list link memory
    flpe_ram #(
        .WIDTH (LW),
        .DEPTH (POOL_ENTRIES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (r_head[IW-1:0]),
        .o_rdata (link_rdata)
    );

    // handshake and create checks
    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign full     = (r_total == '0) || (r_head >= N_L);
    assign issue    = (r_scan != N_L);
    assign life_ext = (EW + 1)'(i_item.lifetime);
    assign life_sat = (life_ext > LMAX) ? LMAX : life_ext;

    // sequencer: clearing pass, create, tick walk
    always_comb begin
        n_state    = r_state;
        n_scan     = r_scan;
        n_pend     = 1'b0;
        n_pidx     = r_pidx;
        n_head     = r_head;
        n_total    = r_total;
        n_freed    = r_freed;
        n_life     = r_life;
        n_strobe   = 1'b0;
        n_res      = r_res;
        life_we    = 1'b0;
        life_waddr = r_pidx;
        life_wdata = life_rdata - LIFE_BITS'(1);
        link_we    = 1'b0;
        link_waddr = r_pidx;
        link_wdata = r_head;
        unique case (r_state)
            S_INIT: begin
                life_we    = 1'b1;
                life_waddr = r_scan[IW-1:0];
                life_wdata = '0;
                link_we    = 1'b1;
                link_waddr = r_scan[IW-1:0];
                link_wdata = r_scan + LW'(1);
                if (r_scan == NLAST) begin
                    n_state = S_IDLE;
                    n_scan  = '0;
                end else begin
                    n_scan = r_scan + LW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == OP_CREATE) begin
                        n_res.slot        = '0;
                        n_res.freed_count = '0;
                        n_res.free_count  = to_count(r_total);
                        if (full) begin
                            n_res.status = ST_FULL;
                            n_strobe     = 1'b1;
                        end else if (i_item.lifetime == '0) begin
                            n_res.status = ST_ZERO;
                            n_strobe     = 1'b1;
                        end else begin
                            n_life  = life_sat[LIFE_BITS-1:0];
                            n_state = S_CREATE;
                        end
                    end else begin
                        n_state = S_TICK;
                        n_scan  = '0;
                        n_freed = '0;
                    end
                end
            end
            S_CREATE: begin
                // link data for the head slot is back from memory
                life_we           = 1'b1;
                life_waddr        = r_head[IW-1:0];
                life_wdata        = r_life;
                n_head            = link_rdata;
                n_total           = r_total - LW'(1);
                n_res.status      = ST_OK;
                n_res.slot        = to_slot(r_head);
                n_res.freed_count = '0;
                n_res.free_count  = to_count(r_total - LW'(1));
                n_strobe          = 1'b1;
                n_state           = S_IDLE;
            end
            S_TICK: begin
                // read one slot ahead, update the slot read last cycle
                if (issue) begin
                    n_scan = r_scan + LW'(1);
                end
                n_pend = issue;
                n_pidx = r_scan[IW-1:0];
                if (r_pend && (life_rdata != '0)) begin
                    life_we = 1'b1;
                    if (life_rdata == LIFE_BITS'(1)) begin
                        link_we = 1'b1;
                        n_head  = LW'(r_pidx);
                        n_total = r_total + LW'(1);
                        n_freed = r_freed + LW'(1);
                    end
                end
                if (r_pend && !issue) begin
                    n_res.status      = ST_OK;
                    n_res.slot        = '0;
                    n_res.freed_count = to_count(n_freed);
                    n_res.free_count  = to_count(n_total);
                    n_strobe          = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_scan  = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_scan   <= '0;
            r_pend   <= 1'b0;
            r_head   <= '0;
            r_total  <= N_L;
            r_freed  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_scan   <= n_scan;
            r_pend   <= n_pend;
            r_head   <= n_head;
            r_total  <= n_total;
            r_freed  <= n_freed;
            r_strobe <= n_strobe;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_life <= n_life;
        r_res  <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    // free count never exceeds the pool size
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= N_L)
        else $error("free count above pool size");

    // an accepted item either starts work or reports in the next cycle
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy || o_strobe))
        else $error("accepted item made no progress");

    // a create that got past the checks reports in the next cycle
    a_create_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CREATE) |=> (o_strobe && (o_result.status == ST_OK)))
        else $error("create did not complete");

    // rejected creates report slot zero (ticks, which report ST_OK, are not checked here)
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status != ST_OK)) |-> (o_result.slot == '0))
        else $error("nonzero slot on a rejected create");

endmodule
